// ----- rtl/assert_macros.svh -----
// Assertion macros for the queue RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/lqh_pkg.sv -----
// Shared definitions for the linked queue: defaults, request and status codes,
// and the command and status structs between controller and datapath.
// Depends on nothing.
package lqh_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int SCAN_CHUNK     = 16;

  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DEQ = 2'd1;
  localparam logic [1:0] REQ_REM = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_INVALID = 2'd3;

  typedef struct packed {
    logic       load_req;
    logic       load_slot;
    logic       slot_from_head;
    logic       scan_clr;
    logic       scan_next;
    logic       enq_commit;
    logic       link_tail;
    logic       unlink;
    logic       set_status;
    logic [1:0] status_val;
    logic       out_load;
  } lqh_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       head_none;
    logic       target_bad;
    logic       tail_none;
    logic       chunk_found;
    logic       last_chunk;
    logic       out_free;
  } lqh_stat_t;

endpackage

// ----- rtl/lqh_ctrl.sv -----
// Request sequencer for the linked queue.
// Depends on lqh_pkg; drives lqh_dp through command and status structs.
module lqh_ctrl import lqh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  input  lqh_stat_t stat_i,
  output lqh_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LINK   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_UNLINK = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.req_type)
          REQ_ENQ: begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_SCAN;
          end
          REQ_DEQ: begin
            if (stat_i.head_none) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = STAT_EMPTY;
              state_d          = S_RESP;
            end else begin
              cmd_o.load_slot      = 1'b1;
              cmd_o.slot_from_head = 1'b1;
              state_d              = S_READ;
            end
          end
          REQ_REM: begin
            if (stat_i.target_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = STAT_INVALID;
              state_d          = S_RESP;
            end else begin
              cmd_o.load_slot = 1'b1;
              state_d         = S_READ;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.chunk_found) begin
          cmd_o.enq_commit = 1'b1;
          state_d          = stat_i.tail_none ? S_RESP : S_LINK;
        end else if (stat_i.last_chunk) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = STAT_FULL;
          state_d          = S_RESP;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_LINK: begin
        cmd_o.link_tail = 1'b1;
        state_d         = S_RESP;
      end
      S_READ: begin
        state_d = S_UNLINK;
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/lqh_dp.sv -----
// Datapath of the linked queue: slot tables, link pointers, free-slot scan
// and the result register. Depends on lqh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lqh_dp import lqh_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int HW         = $clog2(SLOTS),
  parameter int LW         = $clog2(SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lqh_cmd_t              cmd_i,
  output lqh_stat_t             stat_o,
  input  logic [1:0]            req_type_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  input  logic [HW-1:0]         target_handle_i,
  input  logic                  m_axis_tready_i,
  output logic                  m_axis_tvalid_o,
  output logic [1:0]            status_o,
  output logic [HW-1:0]         new_handle_o,
  output logic [DATA_WIDTH-1:0] pop_data_o,
  output logic [LW-1:0]         entry_count_o
);

  localparam int CHUNK  = (SLOTS < SCAN_CHUNK) ? SLOTS : SCAN_CHUNK;
  localparam int NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
  localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int OW     = $clog2(CHUNK);
  localparam logic [LW-1:0] NONE_LINK = LW'(SLOTS);

  logic [DATA_WIDTH-1:0] data_mem [SLOTS];
  logic [LW-1:0]         next_mem [SLOTS];
  logic [LW-1:0]         prev_mem [SLOTS];

  logic [1:0]            req_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [HW-1:0]         target_q;
  logic [HW-1:0]         slot_q;
  logic [HW-1:0]         link_addr_q;
  logic [CIW-1:0]        chunk_q;
  logic [LW-1:0]         head_q, tail_q, count_q;
  logic [SLOTS-1:0]      in_use_q;
  logic [DATA_WIDTH-1:0] data_rd_q;
  logic [LW-1:0]         next_rd_q, prev_rd_q;
  logic [1:0]            res_status_q;
  logic [HW-1:0]         res_handle_q;
  logic [DATA_WIDTH-1:0] res_pop_q;
  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [HW-1:0]         out_handle_q;
  logic [DATA_WIDTH-1:0] out_pop_q;
  logic [LW-1:0]         out_count_q;

  logic [NCHUNK*CHUNK-1:0] pad_use;
  logic [CHUNK-1:0]        chunk_free;
  logic [OW-1:0]           off;
  logic                    found;
  logic [HW-1:0]           free_slot;
  logic                    target_ge;
  logic                    p_valid, n_valid;

  logic                  nx_we, pv_we;
  logic [HW-1:0]         nx_wa, pv_wa;
  logic [LW-1:0]         nx_wd, pv_wd;

  // free-slot scan, one chunk of slots per cycle
  always_comb begin
    pad_use            = '1;
    pad_use[SLOTS-1:0] = in_use_q;
    chunk_free         = ~pad_use[chunk_q*CHUNK +: CHUNK];
    found              = |chunk_free;
    off                = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (chunk_free[i]) begin
        off = OW'(i);
      end
    end
  end

  assign free_slot = HW'((32'(chunk_q) * CHUNK) + 32'(off));
  assign target_ge = (LW'(target_q) >= NONE_LINK);
  assign p_valid   = (prev_rd_q != NONE_LINK);
  assign n_valid   = (next_rd_q != NONE_LINK);

  always_comb begin
    stat_o.req_type    = req_q;
    stat_o.head_none   = (head_q == NONE_LINK);
    stat_o.target_bad  = target_ge || !in_use_q[target_q];
    stat_o.tail_none   = (tail_q == NONE_LINK);
    stat_o.chunk_found = found;
    stat_o.last_chunk  = (chunk_q == CIW'(NCHUNK - 1));
    stat_o.out_free    = !out_valid_q || m_axis_tready_i;
  end

  // link write ports
  always_comb begin
    nx_we = 1'b0;
    nx_wa = free_slot;
    nx_wd = NONE_LINK;
    pv_we = 1'b0;
    pv_wa = free_slot;
    pv_wd = tail_q;
    if (cmd_i.enq_commit) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end
    if (cmd_i.link_tail) begin
      nx_we = 1'b1;
      nx_wa = link_addr_q;
      nx_wd = LW'(slot_q);
    end
    if (cmd_i.unlink) begin
      nx_we = p_valid;
      nx_wa = prev_rd_q[HW-1:0];
      nx_wd = next_rd_q;
      pv_we = n_valid;
      pv_wa = next_rd_q[HW-1:0];
      pv_wd = prev_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_commit) begin
      data_mem[free_slot] <= data_q;
    end
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    data_rd_q <= data_mem[slot_q];
    next_rd_q <= next_mem[slot_q];
    prev_rd_q <= prev_mem[slot_q];
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q        <= req_type_i;
      data_q       <= push_data_i;
      target_q     <= target_handle_i;
      res_status_q <= STAT_OK;
      res_handle_q <= '0;
      res_pop_q    <= '0;
    end
    if (cmd_i.load_slot) begin
      slot_q <= cmd_i.slot_from_head ? head_q[HW-1:0] : target_q;
    end
    if (cmd_i.enq_commit) begin
      slot_q       <= free_slot;
      link_addr_q  <= tail_q[HW-1:0];
      res_handle_q <= free_slot;
    end
    if (cmd_i.unlink && req_q == REQ_DEQ) begin
      res_pop_q <= data_rd_q;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status_val;
    end
    if (cmd_i.scan_clr) begin
      chunk_q <= '0;
    end else if (cmd_i.scan_next) begin
      chunk_q <= chunk_q + CIW'(1);
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_pop_q    <= res_pop_q;
      out_count_q  <= count_q;
    end
  end

  // list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NONE_LINK;
      tail_q      <= NONE_LINK;
      count_q     <= '0;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.enq_commit) begin
        tail_q              <= LW'(free_slot);
        in_use_q[free_slot] <= 1'b1;
        count_q             <= count_q + LW'(1);
        if (tail_q == NONE_LINK) begin
          head_q <= LW'(free_slot);
        end
      end
      if (cmd_i.unlink) begin
        in_use_q[slot_q] <= 1'b0;
        count_q          <= count_q - LW'(1);
        if (!p_valid) begin
          head_q <= next_rd_q;
        end
        if (!n_valid) begin
          tail_q <= prev_rd_q;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign status_o        = out_status_q;
  assign new_handle_o    = out_handle_q;
  assign pop_data_o      = out_pop_q;
  assign entry_count_o   = out_count_q;

  `ASSERT_CLKD(a_count_range, clk_i, rst_ni, count_q <= NONE_LINK, "entry count above slot total")
  `ASSERT_CLKD(a_count_use, clk_i, rst_ni, 32'(count_q) == $countones(in_use_q), "count differs from slots in use")
  `ASSERT_CLKD(a_head_empty, clk_i, rst_ni, (head_q == NONE_LINK) == (count_q == '0), "head and count disagree")
  `ASSERT_ALWAYS(a_reset_clear, clk_i, !rst_ni |-> (count_q == '0 && !out_valid_q), "state not cleared in reset")

endmodule

// ----- rtl/linked_queue_with_handle_remove.sv -----
// Linked queue with removal by handle: FIFO kept as a doubly linked list over a slot table.
// Top level; depends on lqh_pkg, lqh_ctrl and lqh_dp.
//
// One request is handled at a time. An enqueue passes through decode, the search
// for the lowest free slot, one group of 16 slots at a time (up to ceil(SLOTS/16)
// groups), a link step when the queue already holds an entry, and the response;
// a dequeue or a remove passes through decode, a table read, the unlink and the
// response. An empty dequeue, a stale remove or an unused request type goes from
// decode straight to the response, and an enqueue that finds the queue full
// responds after searching every group. These steps are set by the single write
// port of each link table, its registered read, and the 16-slot-per-cycle free
// slot search. A held result does not stop the next request from being taken;
// completion waits only until the result register is free. There is no clearing
// pass after reset: the slot tables are read only for slots in use.
module linked_queue_with_handle_remove import lqh_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           s_axis_tvalid_i,
  output logic                                           s_axis_tready_o,
  // push_data, target_handle, zero fill
  input  logic [((DATA_WIDTH+$clog2(SLOTS)+7)/8)*8-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [1:0]                                     s_axis_tuser_i,
  output logic                                           m_axis_tvalid_o,
  input  logic                                           m_axis_tready_i,
  // new_handle, pop_data, entry_count, zero fill
  output logic [(($clog2(SLOTS)+DATA_WIDTH+$clog2(SLOTS+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [1:0]                                     m_axis_tuser_o
);

  localparam int HW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);

  lqh_cmd_t              cmd;
  lqh_stat_t             stat;
  logic [HW-1:0]         new_handle;
  logic [DATA_WIDTH-1:0] pop_data;
  logic [LW-1:0]         entry_count;

  lqh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  lqh_dp #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH),
    .HW         (HW),
    .LW         (LW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (s_axis_tuser_i),
    .push_data_i     (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .target_handle_i (s_axis_tdata_i[DATA_WIDTH +: HW]),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .status_o        (m_axis_tuser_o),
    .new_handle_o    (new_handle),
    .pop_data_o      (pop_data),
    .entry_count_o   (entry_count)
  );

  always_comb begin
    m_axis_tdata_o                              = '0;
    m_axis_tdata_o[HW-1:0]                      = new_handle;
    m_axis_tdata_o[HW +: DATA_WIDTH]            = pop_data;
    m_axis_tdata_o[HW+DATA_WIDTH +: LW]         = entry_count;
  end

endmodule
